// File: hdl/msbr_pkg.sv
// Shared types and constants for the MSB-first bit reader.
// Operation and status codes, field widths and the core's flag record.
// No dependencies.
package msbr_pkg;

  localparam int STORE_BYTES_DEF   = 8;
  localparam int MAX_READ_BITS_DEF = 32;
  localparam int FIELD_W           = 32;
  localparam int HELD_W            = 7;
  localparam int WANT_W            = 6;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_READ  = 3'd1,
    OP_PEEK  = 3'd2,
    OP_ALIGN = 3'd3,
    OP_END   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_WAIT    = 2'd1,
    ST_ERROR   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  // Control state of the reader, passed between top level and core
  typedef struct packed {
    logic [HELD_W-1:0] held;
    logic              ended;
    logic              err;
  } msbr_flags_t;

endpackage

// File: hdl/msbr_in_if.sv
// Request channel of the MSB-first bit reader: valid/ready plus one request word.
// Depends on msbr_pkg for field widths.
interface msbr_in_if
  import msbr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [7:0]        data_byte;
  logic [WANT_W-1:0] bits_wanted;

  modport source (output valid, output operation, output data_byte, output bits_wanted,
                  input ready);
  modport sink   (input valid, input operation, input data_byte, input bits_wanted,
                  output ready);
endinterface

// File: hdl/msbr_out_if.sv
// Result channel of the MSB-first bit reader: valid/ready plus one result word.
// Depends on msbr_pkg for field widths.
interface msbr_out_if
  import msbr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] field_value;
  logic [1:0]         status;
  logic               byte_aligned;
  logic               stream_empty;
  logic [HELD_W-1:0]  bits_available;

  modport source (output valid, output field_value, output status, output byte_aligned,
                  output stream_empty, output bits_available, input ready);
  modport sink   (input valid, input field_value, input status, input byte_aligned,
                  input stream_empty, input bits_available, output ready);
endinterface

// File: hdl/msbr_core.sv
// Next-state and result logic of the MSB-first bit reader for one request word.
// Purely combinational; depends on msbr_pkg.
module msbr_core
  import msbr_pkg::*;
#(
  parameter int STORE_BYTES   = STORE_BYTES_DEF,
  parameter int MAX_READ_BITS = MAX_READ_BITS_DEF
) (
  input  logic [2:0]                                        operation,
  input  logic [7:0]                                        data_byte,
  input  logic [WANT_W-1:0]                                 bits_wanted,
  input  logic [((STORE_BYTES*8 < 64) ? STORE_BYTES*8 : 64)-1:0] store,
  input  msbr_flags_t                                       flags,
  output logic [((STORE_BYTES*8 < 64) ? STORE_BYTES*8 : 64)-1:0] store_nxt,
  output msbr_flags_t                                       flags_nxt,
  output logic [FIELD_W-1:0]                                field_value,
  output logic [1:0]                                        status
);

  localparam int STORE_BITS = (STORE_BYTES*8 < 64) ? STORE_BYTES*8 : 64;
  localparam logic [7:0]        STORE_BITS_W = 8'(STORE_BITS);
  localparam logic [WANT_W-1:0] MAX_N        = WANT_W'(MAX_READ_BITS);

  logic [WANT_W-1:0]     n;
  logic [HELD_W-1:0]     shamt;
  logic [HELD_W-1:0]     held_after_read;
  logic [HELD_W-1:0]     held_after_align;
  logic [STORE_BITS-1:0] shifted;
  logic [FIELD_W-1:0]    field_mask;
  logic [FIELD_W-1:0]    extracted;
  logic                  push_full;
  logic                  short_req;

  always_comb begin
    n                = (bits_wanted > MAX_N) ? MAX_N : bits_wanted;
    shamt            = flags.held - {1'b0, n};
    held_after_read  = shamt;
    held_after_align = {flags.held[HELD_W-1:3], 3'b000};
    shifted          = store >> shamt;
    field_mask       = (n == '0) ? '0 : ({FIELD_W{1'b1}} >> (7'(FIELD_W) - {1'b0, n}));
    extracted        = shifted[FIELD_W-1:0] & field_mask;
    push_full        = ({1'b0, flags.held} + 8'd8) > STORE_BITS_W;
    short_req        = {1'b0, n} > flags.held;
  end

  always_comb begin
    store_nxt   = store;
    flags_nxt   = flags;
    field_value = '0;
    status      = ST_DONE;
    unique case (operation) inside
      OP_PUSH: begin
        if (flags.ended || push_full) begin
          status = ST_REFUSED;
        end else begin
          store_nxt      = {store[STORE_BITS-9:0], data_byte};
          flags_nxt.held = flags.held + 7'd8;
        end
      end
      OP_READ, OP_PEEK: begin
        if (flags.err) begin
          status = ST_ERROR;
        end else if (short_req) begin
          if (flags.ended) begin
            flags_nxt.err = 1'b1;
            status        = ST_ERROR;
          end else begin
            status = ST_WAIT;
          end
        end else begin
          field_value = extracted;
          if (operation == OP_READ) begin
            // drop the bits just taken and clear them out of the store
            flags_nxt.held = held_after_read;
            store_nxt      = store & ~({STORE_BITS{1'b1}} << held_after_read);
          end
        end
      end
      OP_ALIGN: begin
        if (flags.err) begin
          status = ST_ERROR;
        end else begin
          flags_nxt.held = held_after_align;
          store_nxt      = store & ~({STORE_BITS{1'b1}} << held_after_align);
        end
      end
      OP_END: begin
        flags_nxt.ended = 1'b1;
      end
      default: begin
        status = ST_ERROR;
      end
    endcase
  end

endmodule

// File: hdl/msb_first_bit_reader_unit.sv
// MSB-first bit reader: bytes in, fields of 0 to 32 bits out.
// Top level; depends on msbr_pkg, msbr_in_if, msbr_out_if and msbr_core.
//
// Usage:
//   in_ch carries one request word: operation (push byte, read, peek, align,
//   mark end), data_byte and bits_wanted. out_ch returns exactly one result word
//   per request: field_value, status, byte_aligned, stream_empty and
//   bits_available after the request.
//   The result of a request is registered at the clock edge that accepts it and
//   is valid in the cycle after that edge. Throughput: one request per cycle while
//   the receiver keeps up; the bit store and its counters update at that same edge,
//   so the next request sees the new state at once.
//   A result waiting in the output register does not block a new request when
//   out_ch.ready is high in that cycle; while the receiver stalls, in_ch.ready
//   drops and the pending result holds.
//   Reset (rst_n low, synchronous) empties the store, clears the end-of-input
//   and sticky error flags and drops any pending result.
module msb_first_bit_reader_unit
  import msbr_pkg::*;
#(
  parameter int STORE_BYTES   = STORE_BYTES_DEF,
  parameter int MAX_READ_BITS = MAX_READ_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  msbr_in_if.sink    in_ch,
  msbr_out_if.source out_ch
);

  localparam int STORE_BITS = (STORE_BYTES*8 < 64) ? STORE_BYTES*8 : 64;

  logic [STORE_BITS-1:0] store_r;
  logic [STORE_BITS-1:0] store_nxt;
  msbr_flags_t           flags_r;
  msbr_flags_t           flags_nxt;
  logic [FIELD_W-1:0]    field_nxt;
  logic [1:0]            status_nxt;

  logic                  out_valid_r;
  logic [FIELD_W-1:0]    field_value_r;
  logic [1:0]            status_r;
  logic                  byte_aligned_r;
  logic                  stream_empty_r;
  logic [HELD_W-1:0]     bits_available_r;
  logic                  accept;

  msbr_core #(
    .STORE_BYTES   (STORE_BYTES),
    .MAX_READ_BITS (MAX_READ_BITS)
  ) u_core (
    .operation   (in_ch.operation),
    .data_byte   (in_ch.data_byte),
    .bits_wanted (in_ch.bits_wanted),
    .store       (store_r),
    .flags       (flags_r),
    .store_nxt   (store_nxt),
    .flags_nxt   (flags_nxt),
    .field_value (field_nxt),
    .status      (status_nxt)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r     <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      store_r     <= store_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      field_value_r    <= field_nxt;
      status_r         <= status_nxt;
      byte_aligned_r   <= (flags_nxt.held[2:0] == 3'd0);
      stream_empty_r   <= flags_nxt.ended && (flags_nxt.held == '0);
      bits_available_r <= flags_nxt.held;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.field_value    = field_value_r;
  assign out_ch.status         = status_r;
  assign out_ch.byte_aligned   = byte_aligned_r;
  assign out_ch.stream_empty   = stream_empty_r;
  assign out_ch.bits_available = bits_available_r;

endmodule

// File: bench/tb.sv
// Testbench for msb_first_bit_reader_unit: directed and random request words with random
// idling on both channels, every result checked against an in-bench bit reader predictor.
// Depends on msbr_pkg, msbr_in_if, msbr_out_if and the reader RTL.
`timescale 1ns / 1ps

module tb
  import msbr_pkg::*;
();

  localparam int STORE_BITS   = (STORE_BYTES_DEF * 8 < 64) ? STORE_BYTES_DEF * 8 : 64;
  localparam int RANDOM_WORDS = 1000;
  localparam int HOLD_AT      = 300;   // words sent before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam logic [2:0] OP_LAST_CODE = 3'd7;  // highest encodable operation

  typedef struct {
    logic [2:0]        op;
    logic [7:0]        data;
    logic [WANT_W-1:0] want;
  } req_t;

  typedef struct {
    logic [FIELD_W-1:0] value;
    status_t            status;
    logic               aligned;
    logic               empty;
    logic [HELD_W-1:0]  avail;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  msbr_in_if  in_ch ();
  msbr_out_if out_ch ();

  msb_first_bit_reader_unit #(
    .STORE_BYTES   (STORE_BYTES_DEF),
    .MAX_READ_BITS (MAX_READ_BITS_DEF)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [63:0] shadow_store = '0;
  int unsigned shadow_held  = 0;
  logic        shadow_ended = 1'b0;
  logic        shadow_err   = 1'b0;

  req_t    request_queue[$];
  result_t field_results_due[$];
  req_t    cur_req;
  result_t due_field;
  int      words_queued = 0;
  int      words_sent   = 0;
  int      field_errors = 0;
  int      send_gap     = 0;
  int      send_calm    = 0;
  int      recv_gap     = 0;
  int      recv_calm    = 0;
  int      hold_left    = 0;
  logic    hold_done    = 1'b0;
  int      cycle_count  = 0;

  function automatic logic [63:0] low_ones(int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic void discard_bits(int unsigned k);
    shadow_held  -= k;
    shadow_store &= low_ones(shadow_held);
  endfunction

  // Apply one request word to the predictor state and return its result word
  function automatic result_t next_field_result(req_t rq);
    result_t     res;
    int unsigned n;
    res.value  = '0;
    res.status = ST_DONE;
    n = (rq.want > MAX_READ_BITS_DEF) ? MAX_READ_BITS_DEF : rq.want;
    case (rq.op) inside
      OP_PUSH: begin
        if (shadow_ended || shadow_held + 8 > STORE_BITS) begin
          res.status = ST_REFUSED;
        end else begin
          shadow_store = (shadow_store << 8) | 64'(rq.data);
          shadow_held += 8;
        end
      end
      OP_READ, OP_PEEK: begin
        if (shadow_err) begin
          res.status = ST_ERROR;
        end else if (n > shadow_held) begin
          if (shadow_ended) begin
            shadow_err = 1'b1;
            res.status = ST_ERROR;
          end else begin
            res.status = ST_WAIT;
          end
        end else if (n > 0) begin
          res.value = FIELD_W'((shadow_store >> (shadow_held - n)) & low_ones(n));
          if (rq.op == OP_READ) discard_bits(n);
        end
      end
      OP_ALIGN: begin
        if (shadow_err) res.status = ST_ERROR;
        else discard_bits(shadow_held % 8);
      end
      OP_END: begin
        shadow_ended = 1'b1;
      end
      default: begin
        res.status = ST_ERROR;
      end
    endcase
    res.aligned = (shadow_held % 8) == 0;
    res.empty   = shadow_ended && (shadow_held == 0);
    res.avail   = HELD_W'(shadow_held);
    return res;
  endfunction

  // Idle length after a word: mostly none or short, a few long, with calm stretches
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic add_req(logic [2:0] op, logic [7:0] data, logic [WANT_W-1:0] want);
    req_t rq;
    rq.op   = op;
    rq.data = data;
    rq.want = want;
    request_queue.push_back(rq);
    words_queued++;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        field_results_due.push_back(next_field_result(cur_req));
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          cur_req = request_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.operation   <= cur_req.op;
          in_ch.data_byte   <= cur_req.data;
          in_ch.bits_wanted <= cur_req.want;
          send_gap = idle_len(send_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, once, while the sender keeps offering words
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (field_results_due.size() == 0) begin
          $display("%0t: result word with none expected, got value %h status %0d", $time,
                   out_ch.field_value, out_ch.status);
          field_errors++;
        end else begin
          due_field = field_results_due.pop_front();
          if (out_ch.field_value !== due_field.value) begin
            $display("%0t: field_value expected %h, got %h", $time, due_field.value,
                     out_ch.field_value);
            field_errors++;
          end
          if (out_ch.status !== due_field.status) begin
            $display("%0t: status expected %0d, got %0d", $time, due_field.status,
                     out_ch.status);
            field_errors++;
          end
          if (out_ch.byte_aligned !== due_field.aligned) begin
            $display("%0t: byte_aligned expected %b, got %b", $time, due_field.aligned,
                     out_ch.byte_aligned);
            field_errors++;
          end
          if (out_ch.stream_empty !== due_field.empty) begin
            $display("%0t: stream_empty expected %b, got %b", $time, due_field.empty,
                     out_ch.stream_empty);
            field_errors++;
          end
          if (out_ch.bits_available !== due_field.avail) begin
            $display("%0t: bits_available expected %0d, got %0d", $time, due_field.avail,
                     out_ch.bits_available);
            field_errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (hold_left == 0);
        recv_gap = idle_len(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int          r;
    int          sel;
    int          want;
    int unsigned left;
    int unsigned chunk;
    logic        fill_phase;

    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_PUSH;
    in_ch.data_byte   = '0;
    in_ch.bits_wanted = '0;
    out_ch.ready      = 1'b0;

    // Empty store: zero-bit read, waiting read and peek, harmless align
    add_req(OP_READ, 8'h00, 6'd0);
    add_req(OP_READ, 8'hFF, 6'd5);
    add_req(OP_PEEK, 8'h00, 6'd32);
    add_req(OP_ALIGN, 8'h00, 6'd0);
    // Fill to capacity, then one push too many
    add_req(OP_PUSH, 8'hFF, 6'd63);
    add_req(OP_PUSH, 8'h00, 6'd0);
    add_req(OP_PUSH, 8'hA5, 6'd0);
    add_req(OP_PUSH, 8'h5A, 6'd0);
    add_req(OP_PUSH, 8'h80, 6'd0);
    add_req(OP_PUSH, 8'h01, 6'd0);
    add_req(OP_PUSH, 8'hC3, 6'd0);
    add_req(OP_PUSH, 8'h3C, 6'd0);
    add_req(OP_PUSH, 8'h42, 6'd0);
    // Oversized peek saturates; odd read then align
    add_req(OP_PEEK, 8'h00, 6'd63);
    add_req(OP_READ, 8'h00, 6'd1);
    add_req(OP_ALIGN, 8'h00, 6'd0);
    add_req(OP_READ, 8'h00, 6'd32);
    add_req(OP_PEEK, 8'h00, 6'd13);
    add_req(OP_READ, 8'h00, 6'd40);
    for (int k = OP_END + 1; k <= OP_LAST_CODE; k++) add_req(3'(k), 8'hFF, 6'd63);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Alternate fill-heavy and drain-heavy stretches so both full and empty stores show up
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      fill_phase = ((i / 64) % 2) == 0;
      r   = $urandom_range(0, 99);
      sel = $urandom_range(0, 9);
      if (sel < 6) want = $urandom_range(1, 12);
      else if (sel < 8) want = $urandom_range(13, 32);
      else if (sel == 8) want = $urandom_range(0, 1) * 32;
      else want = $urandom_range(33, 63);
      if (r < 2) begin
        add_req(3'($urandom_range(OP_END + 1, OP_LAST_CODE)), 8'($urandom),
                WANT_W'($urandom));
      end else if (r < (fill_phase ? 60 : 30)) begin
        add_req(OP_PUSH, 8'($urandom), WANT_W'($urandom));
      end else if (r < (fill_phase ? 78 : 72)) begin
        add_req(OP_READ, 8'($urandom), WANT_W'(want));
      end else if (r < 93) begin
        add_req(OP_PEEK, 8'($urandom), WANT_W'(want));
      end else begin
        add_req(OP_ALIGN, 8'($urandom), WANT_W'($urandom));
      end
    end

    // Hold the sender until every result is back, then drain and close the stream
    while (words_sent != words_queued || field_results_due.size() != 0) @(posedge clk);
    add_req(OP_ALIGN, 8'h00, 6'd0);
    left = shadow_held - (shadow_held % 8);
    while (left > 0) begin
      chunk = (left > 32) ? 32 : left;
      add_req(OP_READ, 8'h00, WANT_W'(chunk));
      left -= chunk;
    end
    add_req(OP_END, 8'h00, 6'd0);
    add_req(OP_END, 8'h00, 6'd0);
    add_req(OP_PUSH, 8'h77, 6'd0);
    add_req(OP_READ, 8'h00, 6'd0);
    add_req(OP_PEEK, 8'h00, 6'd1);
    add_req(OP_READ, 8'h00, 6'd0);
    add_req(OP_ALIGN, 8'h00, 6'd0);
    add_req(OP_PUSH, 8'h99, 6'd0);
    add_req(OP_LAST_CODE, 8'h00, 6'd0);

    while (words_sent != words_queued || field_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (field_errors == 0 && field_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/msbr_pkg.sv
hdl/msbr_in_if.sv
hdl/msbr_out_if.sv
hdl/msbr_core.sv
hdl/msb_first_bit_reader_unit.sv
bench/tb.sv
